// ----- rtl/tscl_pkg.sv -----
// ----------------------------------------------------------------------------
// tscl_pkg: shared types and constants
// Codes, bounds and word types for the time scale counter with leap second.
// ----------------------------------------------------------------------------
`default_nettype none

package tscl_pkg;

   // Upper bounds of the time fields (lower bounds are zero)
   localparam logic [10:0] DAY_MAX      = 11'd1460;
   localparam logic [4:0]  PERIOD_MAX   = 5'd15;
   localparam logic [4:0]  HOUR_MAX     = 5'd23;
   localparam logic [5:0]  MINUTE_MAX   = 6'd59;
   localparam logic [5:0]  SECOND_LIMIT = 6'd60;

   // Last second of a minute: normal, leap add, leap drop
   localparam logic [5:0]  NORMAL_LAST_SECOND = 6'd59;
   localparam logic [5:0]  ADD_LAST_SECOND    = 6'd60;
   localparam logic [5:0]  DROP_LAST_SECOND   = 6'd58;

   // Register reset values
   localparam logic [4:0]  CORR_HOUR_RESET   = 5'd23;
   localparam logic [5:0]  CORR_MINUTE_RESET = 6'd59;

   localparam int unsigned CSR_DATA_WIDTH  = 6;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_LOAD    = 2'd1,
      CMD_COMPARE = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ADD  = 2'd1,
      MODE_DROP = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ORDER_LESS    = 2'd0,
      ORDER_EQUAL   = 2'd1,
      ORDER_GREATER = 2'd2
   } order_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE   = 2'd0,
      CSR_HOUR   = 2'd1,
      CSR_MINUTE = 2'd2
   } csr_index_type;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // Field order matches significance, so a packed compare orders times
   typedef struct packed {
      logic [4:0]  period;
      logic [10:0] day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } time_type;

   typedef struct packed {
      logic [1:0] command;
      time_type   given;
   } cmd_word_type;

   typedef struct packed {
      logic       status;
      logic [1:0] order;
      time_type   now;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] hour;
      logic [5:0] minute;
   } corr_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/tscl_if.sv -----
// ----------------------------------------------------------------------------
// tscl_if: valid/ready channels
// Command channel and result channel of the time scale counter.
// ----------------------------------------------------------------------------
`default_nettype none

interface tscl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [4:0]  given_period;
   logic [10:0] given_day;
   logic [4:0]  given_hour;
   logic [5:0]  given_minute;
   logic [5:0]  given_second;

   modport source (
      output valid, command, given_period, given_day, given_hour,
             given_minute, given_second,
      input  ready
   );
   modport sink (
      input  valid, command, given_period, given_day, given_hour,
             given_minute, given_second,
      output ready
   );
endinterface

interface tscl_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [1:0]  order;
   logic [4:0]  now_period;
   logic [10:0] now_day;
   logic [4:0]  now_hour;
   logic [5:0]  now_minute;
   logic [5:0]  now_second;

   modport source (
      output valid, status, order, now_period, now_day, now_hour,
             now_minute, now_second,
      input  ready
   );
   modport sink (
      input  valid, status, order, now_period, now_day, now_hour,
             now_minute, now_second,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/time_scale_counter_leap_second_unit.sv -----
// ----------------------------------------------------------------------------
// time_scale_counter_leap_second_unit: time of day counter with leap second
// Top level: command channel, correction registers and result channel.
// ----------------------------------------------------------------------------
// Keeps period / day / hour / minute / second and runs one command word per
// clock while the result buffer has room: tick (one second, with a configurable
// leap second in the correction minute), load (stored only if every field is in
// bounds, else status = 1) or compare (order of the given time against the held
// one). Every result word carries the time held after its command. A command
// passes the input register, then the time registers and result buffer update
// together. The time register feeds back through the carry chain. The two-entry
// result buffer lets commands keep flowing while a result waits. The user must
// write correction registers through csr_* only while the unit is idle; the
// unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module time_scale_counter_leap_second_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   tscl_req_if.sink                                    req_bus,
   tscl_rsp_if.source                                  rsp_bus,
   input  wire logic                                   csr_write_enable,
   input  wire logic [tscl_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [tscl_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   tscl_pkg::corr_cfg_type cfg_ff;
   tscl_pkg::cmd_word_type req_word, core_word;
   tscl_pkg::rsp_word_type core_rsp, out_word;
   logic                   word_valid;
   logic                   room;
   logic                   take;

   // correction registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= tscl_pkg::MODE_OFF;
         cfg_ff.hour   <= tscl_pkg::CORR_HOUR_RESET;
         cfg_ff.minute <= tscl_pkg::CORR_MINUTE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tscl_pkg::CSR_MODE:   cfg_ff.mode   <= csr_write_data[1:0];
            tscl_pkg::CSR_HOUR:   cfg_ff.hour   <= csr_write_data[4:0];
            tscl_pkg::CSR_MINUTE: cfg_ff.minute <= csr_write_data[5:0];
            default:              cfg_ff        <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_word.command      = req_bus.command;
      req_word.given.period = req_bus.given_period;
      req_word.given.day    = req_bus.given_day;
      req_word.given.hour   = req_bus.given_hour;
      req_word.given.minute = req_bus.given_minute;
      req_word.given.second = req_bus.given_second;
   end

   // core runs a word whenever the result buffer has a free slot
   assign take = word_valid && room;

   tscl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_word    (req_word),
      .word_valid (word_valid),
      .word       (core_word),
      .take       (take)
   );

   tscl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .take     (take),
      .word     (core_word),
      .rsp_word (core_rsp)
   );

   tscl_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_word (core_rsp),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_word  (out_word)
   );

   always_comb begin
      rsp_bus.status     = out_word.status;
      rsp_bus.order      = out_word.order;
      rsp_bus.now_period = out_word.now.period;
      rsp_bus.now_day    = out_word.now.day;
      rsp_bus.now_hour   = out_word.now.hour;
      rsp_bus.now_minute = out_word.now.minute;
      rsp_bus.now_second = out_word.now.second;
   end

endmodule

`default_nettype wire

// ----- rtl/tscl_in_stage.sv -----
// ----------------------------------------------------------------------------
// tscl_in_stage: command input register
// Holds one command word until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tscl_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire tscl_pkg::cmd_word_type in_word,
   output logic                        word_valid,
   output tscl_pkg::cmd_word_type      word,
   input  wire logic                   take
);

   logic                   valid_ff, valid_in;
   tscl_pkg::cmd_word_type word_ff;

   assign in_ready   = !valid_ff || take;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tscl_core.sv -----
// ----------------------------------------------------------------------------
// tscl_core: time registers and command logic
// Tick carry chain with leap second, bounded load and time compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tscl_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tscl_pkg::corr_cfg_type cfg,
   input  wire logic                   take,
   input  wire tscl_pkg::cmd_word_type word,
   output tscl_pkg::rsp_word_type      rsp_word
);

   tscl_pkg::time_type now_ff, now_in, ticked;
   logic [5:0]         last_second;
   logic               in_corr_minute;
   logic               load_ok;
   logic               status;
   logic [1:0]         order;

   // Length of the current minute
   always_comb begin
      in_corr_minute = (now_ff.hour == cfg.hour) && (now_ff.minute == cfg.minute);
      last_second    = tscl_pkg::NORMAL_LAST_SECOND;
      if (in_corr_minute) begin
         case (cfg.mode)
            tscl_pkg::MODE_ADD:  last_second = tscl_pkg::ADD_LAST_SECOND;
            tscl_pkg::MODE_DROP: last_second = tscl_pkg::DROP_LAST_SECOND;
            default:             last_second = tscl_pkg::NORMAL_LAST_SECOND;
         endcase
      end
   end

   // One second carry chain; full wrap clears everything
   always_comb begin
      ticked = now_ff;
      if (now_ff.second < last_second) begin
         ticked.second = now_ff.second + 6'd1;
      end else begin
         ticked.second = '0;
         if (now_ff.minute < tscl_pkg::MINUTE_MAX) begin
            ticked.minute = now_ff.minute + 6'd1;
         end else begin
            ticked.minute = '0;
            if (now_ff.hour < tscl_pkg::HOUR_MAX) begin
               ticked.hour = now_ff.hour + 5'd1;
            end else begin
               ticked.hour = '0;
               if (now_ff.day < tscl_pkg::DAY_MAX) begin
                  ticked.day = now_ff.day + 11'd1;
               end else begin
                  ticked.day = '0;
                  if (now_ff.period < tscl_pkg::PERIOD_MAX) begin
                     ticked.period = now_ff.period + 5'd1;
                  end else begin
                     ticked.period = '0;
                  end
               end
            end
         end
      end
   end

   assign load_ok = (word.given.second <= tscl_pkg::SECOND_LIMIT)
                 && (word.given.minute <= tscl_pkg::MINUTE_MAX)
                 && (word.given.hour   <= tscl_pkg::HOUR_MAX)
                 && (word.given.day    <= tscl_pkg::DAY_MAX)
                 && (word.given.period <= tscl_pkg::PERIOD_MAX);

   always_comb begin
      now_in = now_ff;
      status = tscl_pkg::STATUS_OK;
      order  = tscl_pkg::ORDER_LESS;
      case (word.command)
         tscl_pkg::CMD_TICK: begin
            now_in = ticked;
         end
         tscl_pkg::CMD_LOAD: begin
            if (load_ok) begin
               now_in = word.given;
            end else begin
               status = tscl_pkg::STATUS_REJECTED;
            end
         end
         tscl_pkg::CMD_COMPARE: begin
            // packed fields run most significant first
            if (word.given < now_ff) begin
               order = tscl_pkg::ORDER_LESS;
            end else if (word.given == now_ff) begin
               order = tscl_pkg::ORDER_EQUAL;
            end else begin
               order = tscl_pkg::ORDER_GREATER;
            end
         end
         default: begin
            now_in = now_ff;
         end
      endcase
   end

   always_comb begin
      rsp_word.status = status;
      rsp_word.order  = order;
      rsp_word.now    = now_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else if (take) begin
         now_ff <= now_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tscl_out_buf.sv -----
// ----------------------------------------------------------------------------
// tscl_out_buf: two-entry result buffer
// Registers result words and decouples the core from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tscl_out_buf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tscl_pkg::rsp_word_type push_word,
   output logic                        room,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output tscl_pkg::rsp_word_type      out_word
);

   tscl_pkg::rsp_word_type entry_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   pop;

   assign room      = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire
